// ----- design/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define TTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tts assertion failed");

// next-cycle implication, quiet while reset is held
`define TTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tts assertion failed");

`endif

// ----- design/tts_pkg.sv -----
// shared constants, codes and types of the template tag scanner
`default_nettype none
package tts_pkg;

  // name buffer geometry
  localparam int NAME_DEPTH = 64;
  localparam int IDX_W      = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;
  localparam int CNT_W      = $clog2(NAME_DEPTH + 1);
  localparam int RAM_AW     = IDX_W + 1;
  localparam int RAM_DEPTH  = 2 ** RAM_AW;

  // command queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // byte codes
  localparam logic [7:0] SPACE_BYTE = 8'd32;
  localparam logic [7:0] NL_BYTE    = 8'd10;
  localparam logic [7:0] NUL_BYTE   = 8'd0;

  // register file
  localparam int         PADDR_W    = 4;
  localparam logic [1:0] REG_OPEN   = 2'd0;
  localparam logic [1:0] REG_CLOSE  = 2'd1;
  localparam logic [1:0] REG_MAXLEN = 2'd2;
  localparam logic [7:0] OPEN_RST   = 8'd123;
  localparam logic [7:0] CLOSE_RST  = 8'd125;
  localparam logic [6:0] MAXLEN_RST = 7'd50;

  // kinds of emit request
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  typedef struct packed {
    logic [7:0] open_delim;
    logic [7:0] close_delim;
    logic [6:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic             bank;
    logic [CNT_W-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } release_t;

  typedef struct packed {
    logic from_ram;
    logic last;
    logic empty;
    logic too_long;
  } rd_meta_t;

  typedef struct packed {
    logic [7:0] name_char;
    logic       name_last;
    logic       name_empty;
    logic       name_too_long;
  } result_t;

endpackage
`default_nettype wire

// ----- design/tts_if.sv -----
// request channel interfaces: text bytes in, name results out
`default_nettype none
interface tts_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source(output valid, output in_byte, input ready);
  modport sink(input valid, input in_byte, output ready);
endinterface

interface tts_name_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_char;
  logic       name_last;
  logic       name_empty;
  logic       name_too_long;
  modport source(output valid, output name_char, output name_last, output name_empty,
                 output name_too_long, input ready);
  modport sink(input valid, input name_char, input name_last, input name_empty,
               input name_too_long, output ready);
endinterface
`default_nettype wire

// ----- design/tts_ram.sv -----
// generic single-write single-read ram with registered read data
`default_nettype none
module tts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- design/tts_front.sv -----
// scanner front end: tag phase tracking, name buffering, emit requests
`default_nettype none
module tts_front import tts_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_t     cfg_i,
  tts_byte_if.sink      in_ch,
  output ram_wr_t       ram_wr_o,
  output logic          push_o,
  output cmd_t          cmd_o,
  input  wire logic     q_full_i,
  input  wire release_t rel_i
);

  localparam logic [1:0] PH_OUTSIDE   = 2'd0;
  localparam logic [1:0] PH_ONE_OPEN  = 2'd1;
  localparam logic [1:0] PH_INSIDE    = 2'd2;
  localparam logic [1:0] PH_ONE_CLOSE = 2'd3;

  logic [1:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] trim_r, trim_nxt;
  logic             ovf_r, ovf_nxt;
  logic             bank_r, bank_nxt;
  logic [1:0]       busy_r, busy_nxt;

  logic       ready;
  logic       acc;
  logic [7:0] b;
  logic       is_end, is_open, is_close, is_space;

  assign ready       = !q_full_i && !busy_r[bank_r];
  assign in_ch.ready = ready;
  assign acc         = in_ch.valid && ready;
  assign b           = in_ch.in_byte;
  assign is_end      = (b == NL_BYTE) || (b == NUL_BYTE);
  assign is_open     = (b == cfg_i.open_delim);
  assign is_close    = (b == cfg_i.close_delim);
  assign is_space    = (b == SPACE_BYTE);

  always_comb begin
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    trim_nxt      = trim_r;
    ovf_nxt       = ovf_r;
    bank_nxt      = bank_r;
    busy_nxt      = busy_r;
    ram_wr_o.en   = 1'b0;
    ram_wr_o.addr = {bank_r, count_r[IDX_W-1:0]};
    ram_wr_o.data = b;
    push_o        = 1'b0;
    cmd_o.kind    = KIND_NAME;
    cmd_o.bank    = bank_r;
    cmd_o.len     = trim_r;

    if (rel_i.en) begin
      busy_nxt[rel_i.bank] = 1'b0;
    end

    if (acc) begin
      if (is_end) begin
        phase_nxt = PH_OUTSIDE;
        count_nxt = '0;
        trim_nxt  = '0;
        ovf_nxt   = 1'b0;
      end else begin
        case (phase_r)
          PH_OUTSIDE: begin
            if (is_open) begin
              phase_nxt = PH_ONE_OPEN;
            end
          end
          PH_ONE_OPEN: begin
            if (is_open) begin
              phase_nxt = PH_INSIDE;
              count_nxt = '0;
              trim_nxt  = '0;
              ovf_nxt   = 1'b0;
            end else begin
              phase_nxt = PH_OUTSIDE;
            end
          end
          PH_INSIDE: begin
            if (is_close) begin
              phase_nxt = PH_ONE_CLOSE;
            end else if (!((count_r == '0) && is_space)) begin
              // leading spaces never reach the buffer
              if (count_r < CNT_W'(NAME_DEPTH)) begin
                ram_wr_o.en = 1'b1;
                count_nxt   = count_r + CNT_W'(1);
                if (!is_space) begin
                  trim_nxt = count_r + CNT_W'(1);
                end
              end else if (!is_space) begin
                ovf_nxt = 1'b1;
              end
            end
          end
          PH_ONE_CLOSE: begin
            if (is_close) begin
              push_o = 1'b1;
              if (ovf_r || (7'(trim_r) > cfg_i.max_len)) begin
                cmd_o.kind = KIND_ERROR;
              end else if (trim_r == '0) begin
                cmd_o.kind = KIND_EMPTY;
              end else begin
                cmd_o.kind       = KIND_NAME;
                busy_nxt[bank_r] = 1'b1;
                bank_nxt         = !bank_r;
              end
              phase_nxt = PH_OUTSIDE;
            end else begin
              phase_nxt = is_open ? PH_ONE_OPEN : PH_OUTSIDE;
            end
            count_nxt = '0;
            trim_nxt  = '0;
            ovf_nxt   = 1'b0;
          end
          default: begin
            phase_nxt = PH_OUTSIDE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OUTSIDE;
      count_r <= '0;
      trim_r  <= '0;
      ovf_r   <= 1'b0;
      bank_r  <= 1'b0;
      busy_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      trim_r  <= trim_nxt;
      ovf_r   <= ovf_nxt;
      bank_r  <= bank_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/tts_cmd_q.sv -----
// small fifo of emit requests between front and back
`default_nettype none
module tts_cmd_q import tts_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output cmd_t      cmd_o,
  output logic      full_o,
  output logic      empty_o
);

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full_o  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty_o = (cnt_r == '0);
  assign cmd_o   = q_r[rptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_nxt = do_push ? wptr_r + QPTR_W'(1) : wptr_r;
    rptr_nxt = do_pop ? rptr_r + QPTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wptr_r] <= cmd_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/tts_back.sv -----
// emitter back end: reads buffered names out and hands result requests on
`default_nettype none
module tts_back import tts_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty_i,
  input  wire cmd_t              cmd_i,
  output logic                   pop_o,
  output logic      [RAM_AW-1:0] ram_raddr_o,
  input  wire logic [7:0]        ram_rdata_i,
  output release_t               rel_o,
  tts_name_if.source             out_ch
);

  localparam logic [1:0] OUT_FULL = 2'd2;

  logic             busy_r, busy_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic             rd_v_r;
  rd_meta_t         meta_r, meta_nxt;

  result_t          f_r [2];
  logic             f_wp_r, f_rp_r;
  logic [1:0]       f_cnt_r, f_cnt_nxt;

  logic       opop;
  logic [1:0] occ;
  logic       issue;
  logic       is_name;
  logic       last;
  result_t    push_item;
  result_t    head;

  assign head                 = f_r[f_rp_r];
  assign out_ch.valid         = (f_cnt_r != 2'd0);
  assign out_ch.name_char     = head.name_char;
  assign out_ch.name_last     = head.name_last;
  assign out_ch.name_empty    = head.name_empty;
  assign out_ch.name_too_long = head.name_too_long;
  assign opop                 = out_ch.valid && out_ch.ready;

  assign occ     = f_cnt_r + {1'b0, rd_v_r};
  assign issue   = busy_r && ((occ != OUT_FULL) || opop);
  assign is_name = (cmd_r.kind == KIND_NAME);
  assign last    = is_name ? ((k_r + CNT_W'(1)) == cmd_r.len) : 1'b1;
  assign pop_o   = !busy_r && !q_empty_i;

  assign ram_raddr_o = {cmd_r.bank, k_r[IDX_W-1:0]};

  always_comb begin
    busy_nxt          = busy_r;
    cmd_nxt           = cmd_r;
    k_nxt             = k_r;
    meta_nxt.from_ram = is_name;
    meta_nxt.last     = last;
    meta_nxt.empty    = (cmd_r.kind == KIND_EMPTY);
    meta_nxt.too_long = (cmd_r.kind == KIND_ERROR);
    rel_o.en          = 1'b0;
    rel_o.bank        = cmd_r.bank;
    if (pop_o) begin
      busy_nxt = 1'b1;
      cmd_nxt  = cmd_i;
      k_nxt    = '0;
    end else if (issue) begin
      if (last) begin
        // bank is free for the scanner once its last byte is read
        busy_nxt = 1'b0;
        rel_o.en = is_name;
      end else begin
        k_nxt = k_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    push_item.name_char     = meta_r.from_ram ? ram_rdata_i : 8'd0;
    push_item.name_last     = meta_r.last;
    push_item.name_empty    = meta_r.empty;
    push_item.name_too_long = meta_r.too_long;
    f_cnt_nxt = f_cnt_r;
    if (rd_v_r && !opop) begin
      f_cnt_nxt = f_cnt_r + 2'd1;
    end else if (opop && !rd_v_r) begin
      f_cnt_nxt = f_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    k_r    <= k_nxt;
    meta_r <= meta_nxt;
    if (rd_v_r) begin
      f_r[f_wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      rd_v_r  <= 1'b0;
      f_wp_r  <= 1'b0;
      f_rp_r  <= 1'b0;
      f_cnt_r <= 2'd0;
    end else begin
      busy_r  <= busy_nxt;
      rd_v_r  <= issue;
      f_wp_r  <= rd_v_r ? !f_wp_r : f_wp_r;
      f_rp_r  <= opop ? !f_rp_r : f_rp_r;
      f_cnt_r <= f_cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/template_tag_scanner.sv -----
// top level of the template tag scanner: registers, front, queue, back, name ram
`default_nettype none
// template_tag_scanner finds tags of the form open open name close close in a byte
// stream and returns each tag's name with leading and trailing spaces trimmed, one
// byte per result request, the final byte marked by name_last; an all-space or empty
// tag gives one result with name_empty, and a name longer than max_name_length (or
// than the 64-byte buffer) gives one result with name_too_long. newline or nul ends
// the line and drops an unfinished tag. the scanner takes one text byte per cycle;
// inner bytes are written to one half of a two-bank name ram while the emitter reads
// the other half, so the scanner only waits when the bank it writes is still being
// read out or the four-deep request queue is full. the emitter takes a request from
// the queue and then gives its results one by one, paced by the single ram read port
// and a two-entry output buffer. there is no clearing pass after reset.
// registers (apb, byte address 4*i, low two address bits not decoded): 0 open delimiter,
// 1 close delimiter, 2 max name length; writes to index 3 are ignored
module template_tag_scanner import tts_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  tts_byte_if.sink                in_ch,
  tts_name_if.source              out_ch,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  // configuration registers
  logic [7:0] open_r, open_nxt;
  logic [7:0] close_r, close_nxt;
  logic [6:0] maxlen_r, maxlen_nxt;
  logic [1:0] reg_idx;
  logic       wr_en;
  cfg_t       cfg;

  // front to queue to back
  ram_wr_t           ram_wr;
  logic              q_push, q_pop, q_full, q_empty;
  cmd_t              cmd_in, cmd_out;
  release_t          rel;
  logic [RAM_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    open_nxt   = open_r;
    close_nxt  = close_r;
    maxlen_nxt = maxlen_r;
    if (wr_en) begin
      case (reg_idx)
        REG_OPEN:   open_nxt   = pwdata[7:0];
        REG_CLOSE:  close_nxt  = pwdata[7:0];
        REG_MAXLEN: maxlen_nxt = pwdata[6:0];
        default:    ;
      endcase
    end
  end

  // read-back mux
  always_comb begin
    case (reg_idx)
      REG_OPEN:   prdata = {24'd0, open_r};
      REG_CLOSE:  prdata = {24'd0, close_r};
      REG_MAXLEN: prdata = {25'd0, maxlen_r};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r   <= OPEN_RST;
      close_r  <= CLOSE_RST;
      maxlen_r <= MAXLEN_RST;
    end else begin
      open_r   <= open_nxt;
      close_r  <= close_nxt;
      maxlen_r <= maxlen_nxt;
    end
  end

  assign cfg.open_delim  = open_r;
  assign cfg.close_delim = close_r;
  assign cfg.max_len     = maxlen_r;

  // scanner: phase tracking and name buffering
  tts_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_i    (cfg),
    .in_ch    (in_ch),
    .ram_wr_o (ram_wr),
    .push_o   (q_push),
    .cmd_o    (cmd_in),
    .q_full_i (q_full),
    .rel_i    (rel)
  );

  // emit requests waiting for the back end
  tts_cmd_q u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .cmd_i   (cmd_in),
    .pop_i   (q_pop),
    .cmd_o   (cmd_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // two banks of name storage, bank bit on top of the address
  tts_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_name_ram (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // emitter
  tts_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty_i   (q_empty),
    .cmd_i       (cmd_out),
    .pop_o       (q_pop),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .rel_o       (rel),
    .out_ch      (out_ch)
  );

endmodule
`default_nettype wire

// ----- design/tts_checker.sv -----
// port-level assertion checker for the template tag scanner, with its bind
`default_nettype none
`include "assert_macros.svh"
module tts_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] name_char,
  input wire logic       name_last,
  input wire logic       name_empty,
  input wire logic       name_too_long
);

  logic [10:0] out_bits;
  logic        flagged;

  assign out_bits = {name_char, name_last, name_empty, name_too_long};
  assign flagged  = name_empty || name_too_long;

  // a stalled result request stays offered and unchanged
  `TTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `TTS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_bits))

  // empty and too-long are exclusive outcomes
  `TTS_ASSERT_NOW(a_flags_excl, out_valid, !(name_empty && name_too_long))

  // an empty or error outcome is a single zero-byte last result
  `TTS_ASSERT_NOW(a_flag_single, out_valid && flagged, name_last && (name_char == 8'd0))

endmodule

bind template_tag_scanner tts_checker u_tts_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .name_char     (out_ch.name_char),
  .name_last     (out_ch.name_last),
  .name_empty    (out_ch.name_empty),
  .name_too_long (out_ch.name_too_long)
);
`default_nettype wire

// ----- test/tb_top.sv -----
// testbench of the template tag scanner: directed text table and predictor-checked random text
`timescale 1ns / 100ps

module tb_top;
  import tts_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 2000000;
  // emitter takes a request, then passes each result through a two-entry buffer
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int REPORT_MAX    = 10;

  localparam logic [1:0] REG_SPARE = 2'd3;   // beyond the register file, must be ignored
  localparam logic [7:0] TAB_BYTE  = 8'd9;
  localparam logic [7:0] BAR_BYTE  = 8'h7C;

  typedef enum logic [1:0] {
    SCAN_OUTSIDE,
    SCAN_ONE_OPEN,
    SCAN_INSIDE,
    SCAN_ONE_CLOSE
  } scan_state_e;

  // one row of directed text: the byte, and the name result typed in where it is obvious
  typedef struct packed {
    logic [7:0] text;
    logic       typed;
    result_t    name;
  } text_row_t;

  localparam result_t NO_NAME    = '0;
  localparam result_t EMPTY_NAME = '{8'h00, 1'b1, 1'b1, 1'b0};
  localparam result_t ERROR_NAME = '{8'h00, 1'b1, 1'b0, 1'b1};

  // rows from LIMIT_ONE_FROM on run with max_name_length set to one
  localparam int LIMIT_ONE_FROM = 19;
  localparam text_row_t DIRECTED [30] = '{
    // empty tag gives a single empty result
    '{OPEN_RST, 1'b0, NO_NAME}, '{OPEN_RST, 1'b0, NO_NAME},
    '{CLOSE_RST, 1'b0, NO_NAME}, '{CLOSE_RST, 1'b1, EMPTY_NAME},
    // spaces trimmed at both ends, tab kept
    '{OPEN_RST, 1'b0, NO_NAME}, '{OPEN_RST, 1'b0, NO_NAME},
    '{SPACE_BYTE, 1'b0, NO_NAME}, '{TAB_BYTE, 1'b0, NO_NAME},
    '{SPACE_BYTE, 1'b0, NO_NAME}, '{CLOSE_RST, 1'b0, NO_NAME},
    '{CLOSE_RST, 1'b1, '{TAB_BYTE, 1'b1, 1'b0, 1'b0}},
    // single close abandons the tag, the following open byte starts a fresh one
    '{OPEN_RST, 1'b0, NO_NAME}, '{OPEN_RST, 1'b0, NO_NAME},
    '{CLOSE_RST, 1'b0, NO_NAME}, '{OPEN_RST, 1'b0, NO_NAME},
    '{OPEN_RST, 1'b0, NO_NAME}, '{"c", 1'b0, NO_NAME},
    '{CLOSE_RST, 1'b0, NO_NAME}, '{CLOSE_RST, 1'b1, '{"c", 1'b1, 1'b0, 1'b0}},
    // over the limit of one gives the error result
    '{OPEN_RST, 1'b0, NO_NAME}, '{OPEN_RST, 1'b0, NO_NAME},
    '{"a", 1'b0, NO_NAME}, '{"b", 1'b0, NO_NAME},
    '{CLOSE_RST, 1'b0, NO_NAME}, '{CLOSE_RST, 1'b1, ERROR_NAME},
    // exactly at the limit is accepted; top byte value
    '{OPEN_RST, 1'b0, NO_NAME}, '{OPEN_RST, 1'b0, NO_NAME},
    '{8'hFF, 1'b0, NO_NAME}, '{CLOSE_RST, 1'b0, NO_NAME},
    '{CLOSE_RST, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tts_byte_if text_ch ();
  tts_name_if name_ch ();

  template_tag_scanner dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (text_ch),
    .out_ch  (name_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // free-running clock, 10 ns period
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // idling controls shared between the stimulus and the result side
  bit tx_idle_en   = 1'b1;
  bit rx_idle_en   = 1'b1;
  bit hold_request = 1'b0;

  int fail_count  = 0;
  int cycle_count = 0;

  // predictor state: its own copy of the registers and of the scanner
  cfg_t        scan_cfg;
  scan_state_e scan_state;
  logic [7:0]  name_chars [NAME_DEPTH];
  logic [CNT_W-1:0] kept_count;
  logic [CNT_W-1:0] trim_len;
  bit          kept_overflow;

  result_t fresh_names[$];     // results caused by the byte just scanned
  result_t pending_names[$];   // results still owed by the block, oldest first

  function automatic void drop_tag();
    kept_count    = '0;
    trim_len      = '0;
    kept_overflow = 1'b0;
  endfunction

  // advance the scanner by one byte, appending any names it completes to fresh_names
  function automatic void scan_byte(input logic [7:0] b);
    result_t r;
    // line end wins over everything, even a delimiter of the same value
    if (b == NL_BYTE || b == NUL_BYTE) begin
      scan_state = SCAN_OUTSIDE;
      drop_tag();
      return;
    end
    case (scan_state)
      SCAN_OUTSIDE: begin
        if (b == scan_cfg.open_delim) scan_state = SCAN_ONE_OPEN;
      end
      SCAN_ONE_OPEN: begin
        if (b == scan_cfg.open_delim) begin
          scan_state = SCAN_INSIDE;
          drop_tag();
        end else begin
          scan_state = SCAN_OUTSIDE;
        end
      end
      SCAN_INSIDE: begin
        // close test first, so equal delimiters still behave
        if (b == scan_cfg.close_delim) begin
          scan_state = SCAN_ONE_CLOSE;
        end else if (!(kept_count == 0 && b == SPACE_BYTE)) begin
          if (kept_count < NAME_DEPTH) begin
            name_chars[kept_count[IDX_W-1:0]] = b;
            kept_count++;
            if (b != SPACE_BYTE) trim_len = kept_count;
          end else if (b != SPACE_BYTE) begin
            // spaces beyond a full buffer are simply dropped
            kept_overflow = 1'b1;
          end
        end
      end
      default: begin
        if (b == scan_cfg.close_delim) begin
          if (kept_overflow || trim_len > scan_cfg.max_len) begin
            fresh_names.push_back(ERROR_NAME);
          end else if (trim_len == 0) begin
            fresh_names.push_back(EMPTY_NAME);
          end else begin
            for (int k = 0; k < trim_len; k++) begin
              r.name_char     = name_chars[k];
              r.name_last     = (k + 1 == trim_len);
              r.name_empty    = 1'b0;
              r.name_too_long = 1'b0;
              fresh_names.push_back(r);
            end
          end
          drop_tag();
          scan_state = SCAN_OUTSIDE;
        end else begin
          // single close: the byte is scanned again as outside text
          drop_tag();
          scan_state = (b == scan_cfg.open_delim) ? SCAN_ONE_OPEN : SCAN_OUTSIDE;
        end
      end
    endcase
  endfunction

  function automatic void note_failure(input string what, input result_t want,
                                       input result_t got);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $display({"mismatch %0d at %0t: %s: expected char %h last %b empty %b too_long %b,",
                " got char %h last %b empty %b too_long %b"},
               fail_count, $realtime, what, want.name_char, want.name_last, want.name_empty,
               want.name_too_long, got.name_char, got.name_last, got.name_empty,
               got.name_too_long);
  endfunction

  // a byte for the inside of a tag, mostly ordinary text with a fair share of blanks
  function automatic logic [7:0] name_byte();
    int p;
    logic [7:0] b;
    p = $urandom_range(0, 99);
    if (p < 20) return SPACE_BYTE;
    if (p < 26) return TAB_BYTE;
    do b = 8'($urandom_range(1, 255));
    while (b == NL_BYTE || b == scan_cfg.close_delim);
    return b;
  endfunction

  // offer one text byte, with an occasional idle burst first, and book its results
  task automatic send_text(input logic [7:0] b, input logic typed,
                           input result_t typed_name);
    if (tx_idle_en && $urandom_range(0, 99) < 10) begin
      text_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    text_ch.valid   <= 1'b1;
    text_ch.in_byte <= b;
    do @(posedge clk);
    while (!text_ch.ready);
    fresh_names.delete();
    scan_byte(b);
    if (typed) begin
      pending_names.push_back(typed_name);
    end else begin
      foreach (fresh_names[i]) pending_names.push_back(fresh_names[i]);
    end
  endtask

  // stop offering, let every owed name arrive, then give the emitter time to go quiet
  task automatic wait_idle();
    text_ch.valid <= 1'b0;
    while (pending_names.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle held until pready, then back to idle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_OPEN:   scan_cfg.open_delim  = value[7:0];
      REG_CLOSE:  scan_cfg.close_delim = value[7:0];
      REG_MAXLEN: scan_cfg.max_len     = value[6:0];
      default: ;
    endcase
  endtask

  // random text, phrase by phrase: mostly whole tags, some broken, some noise
  task automatic run_random_text(input int quota);
    int sent;
    int pick;
    int len_pick;
    int len;
    int lo;
    logic [7:0] other;
    logic [7:0] phrase[$];
    sent = 0;
    while (sent < quota) begin
      phrase.delete();
      repeat ($urandom_range(0, 2)) phrase.push_back(8'($urandom_range(0, 255)));
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
        phrase.push_back(scan_cfg.open_delim);
        phrase.push_back(scan_cfg.open_delim);
        // name length: mostly short, some empty, some near the limit, a few past the buffer
        len_pick = $urandom_range(0, 99);
        lo = (scan_cfg.max_len == 0) ? 0 : scan_cfg.max_len - 1;
        if (len_pick < 8) len = 0;
        else if (len_pick < 14) len = $urandom_range(55, 70);
        else if (len_pick < 24) len = $urandom_range(lo, scan_cfg.max_len + 1);
        else len = $urandom_range(1, 8);
        repeat (len) phrase.push_back(name_byte());
        if (pick < 78) begin
          phrase.push_back(scan_cfg.close_delim);
          phrase.push_back(scan_cfg.close_delim);
        end else begin
          case ($urandom_range(0, 3))
            0: phrase.push_back(NL_BYTE);
            1: phrase.push_back(NUL_BYTE);
            2: begin
              // lone close followed by some other byte
              do other = 8'($urandom_range(0, 255));
              while (other == scan_cfg.close_delim);
              phrase.push_back(scan_cfg.close_delim);
              phrase.push_back(other);
            end
            default: begin
              phrase.push_back(scan_cfg.close_delim);
              phrase.push_back(scan_cfg.open_delim);
            end
          endcase
        end
      end else begin
        repeat ($urandom_range(1, 4)) phrase.push_back(8'($urandom_range(0, 255)));
      end
      foreach (phrase[i]) send_text(phrase[i], 1'b0, NO_NAME);
      sent += phrase.size();
    end
  endtask

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    name_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (!rst_n) begin
        name_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        name_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        name_ch.ready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 99) < 10) begin
        stall_left = $urandom_range(0, 14);
        name_ch.ready <= 1'b0;
      end else begin
        name_ch.ready <= 1'b1;
      end
    end
  end

  // result checker: each accepted request against the oldest owed name
  always @(posedge clk) begin : name_check
    result_t got;
    result_t want;
    if (rst_n && name_ch.valid && name_ch.ready) begin
      got.name_char     = name_ch.name_char;
      got.name_last     = name_ch.name_last;
      got.name_empty    = name_ch.name_empty;
      got.name_too_long = name_ch.name_too_long;
      if (pending_names.size() == 0) begin
        note_failure("result with nothing owed", NO_NAME, got);
      end else begin
        want = pending_names.pop_front();
        if (got.name_char !== want.name_char || got.name_last !== want.name_last ||
            got.name_empty !== want.name_empty || got.name_too_long !== want.name_too_long)
          note_failure("wrong result", want, got);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [7:0] rand_open;
    rst_n           <= 1'b0;
    text_ch.valid   <= 1'b0;
    text_ch.in_byte <= 8'h00;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;

    // predictor starts from the reset values of the block
    scan_cfg.open_delim  = OPEN_RST;
    scan_cfg.close_delim = CLOSE_RST;
    scan_cfg.max_len     = MAXLEN_RST;
    scan_state           = SCAN_OUTSIDE;
    drop_tag();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed table at reset settings, last rows with a limit of one
    foreach (DIRECTED[i]) begin
      if (i == LIMIT_ONE_FROM) begin
        wait_idle();
        write_reg(REG_MAXLEN, 32'd1);
      end
      send_text(DIRECTED[i].text, DIRECTED[i].typed, DIRECTED[i].name);
    end

    // reset delimiters, default limit
    wait_idle();
    write_reg(REG_MAXLEN, {25'd0, MAXLEN_RST});
    run_random_text(70);

    // equal delimiters, full-buffer limit; receiver holds off while text keeps coming
    wait_idle();
    write_reg(REG_OPEN, {24'd0, BAR_BYTE});
    write_reg(REG_CLOSE, {24'd0, BAR_BYTE});
    write_reg(REG_MAXLEN, 32'd64);
    tx_idle_en   = 1'b0;
    hold_request = 1'b1;
    run_random_text(80);
    tx_idle_en = 1'b1;

    // top byte values as delimiters, zero limit: only empty and error names
    wait_idle();
    write_reg(REG_OPEN, 32'h0000_00FF);
    write_reg(REG_CLOSE, 32'h0000_00FE);
    write_reg(REG_MAXLEN, 32'd0);
    run_random_text(40);

    // nul delimiters can never take effect, line end comes first; spare address ignored
    wait_idle();
    write_reg(REG_OPEN, 32'h0000_0000);
    write_reg(REG_CLOSE, 32'h0000_0000);
    write_reg(REG_MAXLEN, 32'd64);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    run_random_text(20);

    // random open byte, close at the top value, random limit
    wait_idle();
    do rand_open = 8'($urandom_range(1, 254));
    while (rand_open == NL_BYTE);
    write_reg(REG_OPEN, {24'd0, rand_open});
    write_reg(REG_CLOSE, 32'h0000_00FF);
    write_reg(REG_MAXLEN, 32'($urandom_range(1, 63)));
    run_random_text(80);

    // last stretch at full rate on both sides
    wait_idle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    write_reg(REG_OPEN, {24'd0, OPEN_RST});
    write_reg(REG_CLOSE, {24'd0, CLOSE_RST});
    write_reg(REG_MAXLEN, 32'd64);
    run_random_text(60);

    wait_idle();
    if (fail_count == 0 && pending_names.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/tts_pkg.sv
design/tts_if.sv
design/tts_ram.sv
design/tts_front.sv
design/tts_cmd_q.sv
design/tts_back.sv
design/template_tag_scanner.sv
design/tts_checker.sv
test/tb_top.sv
